// ----- design/sexp_pkg.sv -----
// shared types and constants for the s-expression token scanner
`default_nettype none

package sexp_pkg;

    // byte classes decoded by the front end
    typedef enum logic [4:0] {
        CH_SPACE,
        CH_NEWLINE,
        CH_SEMI,
        CH_LPAREN,
        CH_RPAREN,
        CH_QUOTE,
        CH_BQUOTE,
        CH_COMMA,
        CH_DQUOTE,
        CH_HASH,
        CH_DOT,
        CH_DIGIT,
        CH_AT,
        CH_BSLASH,
        CH_TRUE,
        CH_FALSE,
        CH_OTHER,
        CH_END
    } char_class_t;

    // token kinds as they leave on tuser
    typedef enum logic [3:0] {
        KIND_LPAREN       = 4'd0,
        KIND_RPAREN       = 4'd1,
        KIND_QUOTE        = 4'd2,
        KIND_BACKQUOTE    = 4'd3,
        KIND_COMMA        = 4'd4,
        KIND_COMMA_AT     = 4'd5,
        KIND_STRING       = 4'd6,
        KIND_BOOLEAN      = 4'd7,
        KIND_NUMBER       = 4'd8,
        KIND_SYMBOL       = 4'd9,
        KIND_END          = 4'd10,
        KIND_UNTERMINATED = 4'd11
    } kind_t;

    localparam int KIND_W      = 4;
    localparam int LEN_W       = 16;
    localparam int COL_W       = 16;
    localparam int CLASS_DEPTH = 4;
    localparam int TOKQ_DEPTH  = 4;

    localparam logic [7:0] CHR_NUL      = 8'h00;
    localparam logic [7:0] CHR_TAB      = 8'h09;
    localparam logic [7:0] CHR_LF       = 8'h0A;
    localparam logic [7:0] CHR_VT       = 8'h0B;
    localparam logic [7:0] CHR_FF       = 8'h0C;
    localparam logic [7:0] CHR_CR       = 8'h0D;
    localparam logic [7:0] CHR_SP       = 8'h20;
    localparam logic [7:0] CHR_DQUOTE   = 8'h22;
    localparam logic [7:0] CHR_HASH     = 8'h23;
    localparam logic [7:0] CHR_QUOTE    = 8'h27;
    localparam logic [7:0] CHR_LPAREN   = 8'h28;
    localparam logic [7:0] CHR_RPAREN   = 8'h29;
    localparam logic [7:0] CHR_COMMA    = 8'h2C;
    localparam logic [7:0] CHR_DOT      = 8'h2E;
    localparam logic [7:0] CHR_DIGIT_LO = 8'h30;
    localparam logic [7:0] CHR_DIGIT_HI = 8'h39;
    localparam logic [7:0] CHR_SEMI     = 8'h3B;
    localparam logic [7:0] CHR_AT       = 8'h40;
    localparam logic [7:0] CHR_UPPER_F  = 8'h46;
    localparam logic [7:0] CHR_UPPER_T  = 8'h54;
    localparam logic [7:0] CHR_BSLASH   = 8'h5C;
    localparam logic [7:0] CHR_BQUOTE   = 8'h60;
    localparam logic [7:0] CHR_LOWER_F  = 8'h66;
    localparam logic [7:0] CHR_LOWER_T  = 8'h74;

endpackage

`default_nettype wire

// ----- design/s_expression_token_scanner.sv -----
// top level of the s-expression token scanner
//
// usage: source bytes enter on the s_axis channel, one byte per transaction;
// a byte of zero or a transaction with tlast high ends the source. tokens
// leave on the m_axis channel, one token per transaction, with the kind on
// tuser and tlast marking the last token caused by one input byte.
// a token is usually closed by the byte that follows it, so one byte may
// cause two tokens; after the end of source all further bytes are taken
// and dropped without output.
// the class of the byte that closes a token is registered in the class
// queue, then the token in the token queue, and from there it is on m_axis.
// throughput: one byte per cycle unless halted; bytes that cause two tokens
// are limited by the single output port to one token per cycle.
// the front end classifies bytes into a four-entry class queue, the scan
// state machine takes one class per cycle whenever the four-entry token
// queue has room for two tokens.
// reset: all queues empty, position at offset 0, line 1, column 0.
// when the receiver stalls the token queue fills, the scanner halts, the
// class queue fills, and s_axis_tready drops; nothing is lost.
`default_nettype none

module s_expression_token_scanner #(
    parameter int OFFSET_BITS = 32,
    parameter int LINE_BITS   = 24,
    localparam int DATA_BITS  = 1 + OFFSET_BITS + 16 + LINE_BITS + 16,
    localparam int TDATA_W    = ((DATA_BITS + 7) / 8) * 8
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire  [7:0]         s_axis_tdata,   // text_byte
    input  wire                s_axis_tlast,   // end_of_input
    output logic               m_axis_tvalid,
    input  wire                m_axis_tready,
    // bool_value, start_offset, text_length, token_line, start_column, zero fill
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [3:0]         m_axis_tuser,   // token_kind
    output logic               m_axis_tlast    // last_of_run
);
    import sexp_pkg::*;

    localparam int ENTRY_W = 1 + KIND_W + TDATA_W;

    logic               head_valid, head_pop, room;
    char_class_t        head_class;
    logic               wr0_en, wr1_en;
    logic [ENTRY_W-1:0] wr0_data, wr1_data, out_data;

    // byte intake and classification
    sexp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_byte     (s_axis_tdata),
        .s_end      (s_axis_tlast),
        .head_valid (head_valid),
        .head_class (head_class),
        .head_pop   (head_pop)
    );

    // scan state and token building
    sexp_lex #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .TDATA_W     (TDATA_W),
        .ENTRY_W     (ENTRY_W)
    ) u_lex (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_class (head_class),
        .head_pop   (head_pop),
        .room       (room),
        .wr0_en     (wr0_en),
        .wr0_data   (wr0_data),
        .wr1_en     (wr1_en),
        .wr1_data   (wr1_data)
    );

    // output token queue
    sexp_tokq #(
        .ENTRY_W (ENTRY_W)
    ) u_tokq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr0_en    (wr0_en),
        .wr0_data  (wr0_data),
        .wr1_en    (wr1_en),
        .wr1_data  (wr1_data),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    // queue entry: last flag, kind, tdata
    assign m_axis_tdata = out_data[TDATA_W-1:0];
    assign m_axis_tuser = out_data[TDATA_W +: KIND_W];
    assign m_axis_tlast = out_data[ENTRY_W-1];

endmodule

`default_nettype wire

// ----- design/sexp_front.sv -----
// front end: accepts source bytes, classifies them and queues the classes
`default_nettype none

module sexp_front (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  [7:0]            s_byte,
    input  wire                   s_end,
    output logic                  head_valid,
    output sexp_pkg::char_class_t head_class,
    input  wire                   head_pop
);
    import sexp_pkg::*;

    localparam int PTR_W = $clog2(CLASS_DEPTH);

    char_class_t      q_mem [CLASS_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    char_class_t      in_class;
    logic             push, pop;

    // byte decoder
    always_comb
    begin
        unique case (s_byte) inside
            CHR_NUL:                              in_class = CH_END;
            CHR_SP, CHR_TAB, CHR_VT, CHR_FF, CHR_CR: in_class = CH_SPACE;
            CHR_LF:                               in_class = CH_NEWLINE;
            CHR_SEMI:                             in_class = CH_SEMI;
            CHR_LPAREN:                           in_class = CH_LPAREN;
            CHR_RPAREN:                           in_class = CH_RPAREN;
            CHR_QUOTE:                            in_class = CH_QUOTE;
            CHR_BQUOTE:                           in_class = CH_BQUOTE;
            CHR_COMMA:                            in_class = CH_COMMA;
            CHR_DQUOTE:                           in_class = CH_DQUOTE;
            CHR_HASH:                             in_class = CH_HASH;
            CHR_DOT:                              in_class = CH_DOT;
            [CHR_DIGIT_LO:CHR_DIGIT_HI]:          in_class = CH_DIGIT;
            CHR_AT:                               in_class = CH_AT;
            CHR_BSLASH:                           in_class = CH_BSLASH;
            CHR_LOWER_T, CHR_UPPER_T:             in_class = CH_TRUE;
            CHR_LOWER_F, CHR_UPPER_F:             in_class = CH_FALSE;
            default:                              in_class = CH_OTHER;
        endcase
        if (s_end)
        begin
            in_class = CH_END;
        end
    end

    assign s_ready    = (count_reg != (PTR_W+1)'(CLASS_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_class = q_mem[rd_ptr_reg];
    assign push       = s_valid && s_ready;
    assign pop        = head_pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_class;
        end
    end

endmodule

`default_nettype wire

// ----- design/sexp_lex.sv -----
// back end: scan state machine that turns byte classes into tokens
`default_nettype none

module sexp_lex #(
    parameter int OFFSET_BITS = 32,
    parameter int LINE_BITS   = 24,
    parameter int TDATA_W     = 96,
    parameter int ENTRY_W     = 101
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   head_valid,
    input  sexp_pkg::char_class_t head_class,
    output logic                  head_pop,
    input  wire                   room,
    output logic                  wr0_en,
    output logic [ENTRY_W-1:0]    wr0_data,
    output logic                  wr1_en,
    output logic [ENTRY_W-1:0]    wr1_data
);
    import sexp_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam int LB = LINE_BITS;
    localparam logic [OB-1:0] LEN_MAX = OB'(32'h0000_FFFF);

    typedef enum logic [8:0] {
        MODE_IDLE    = 9'b000000001,
        MODE_COMMENT = 9'b000000010,
        MODE_SYMBOL  = 9'b000000100,
        MODE_NUMBER  = 9'b000001000,
        MODE_STRING  = 9'b000010000,
        MODE_ESCAPE  = 9'b000100000,
        MODE_COMMA   = 9'b001000000,
        MODE_HASH    = 9'b010000000,
        MODE_DOT     = 9'b100000000
    } scan_mode_t;

    scan_mode_t       mode_reg, mode_next;
    logic             dot_reg, dot_next;
    logic             fin_reg, fin_next;
    logic [OB-1:0]    offset_reg, offset_next;
    logic [LB-1:0]    line_reg, line_next;
    logic [OB-1:0]    line_start_reg, line_start_next;
    logic [OB-1:0]    tok_off_reg, tok_off_next;
    logic [LB-1:0]    tok_line_reg, tok_line_next;
    logic [COL_W-1:0] tok_col_reg, tok_col_next;

    logic [OB-1:0]    col_diff, span_diff, span_less;
    logic [COL_W-1:0] col_now;
    logic [LEN_W-1:0] span0, span1;
    logic             consume, ends_sym;

    // dispatch of a byte in the idle position
    scan_mode_t       d_mode;
    logic             d_begin, d_emit, d_digit;
    kind_t            d_kind;

    // first token (closes the pending one), second token (starts here)
    logic             e0_v, e0_bool, e1_v, run_disp;
    kind_t            e0_kind, e1_kind;
    logic [LEN_W-1:0] e0_len, e1_len;
    logic [TDATA_W-1:0] td0, td1;

    assign consume  = head_valid && room;
    assign head_pop = consume;

    assign col_diff  = offset_reg - line_start_reg;
    assign col_now   = (col_diff > LEN_MAX) ? '1 : col_diff[COL_W-1:0];
    assign span_diff = offset_reg - tok_off_reg;
    assign span_less = span_diff - OB'(1);
    assign span0     = (span_diff > LEN_MAX) ? '1 : span_diff[LEN_W-1:0];
    assign span1     = (span_diff == '0) ? '0
                     : ((span_less > LEN_MAX) ? '1 : span_less[LEN_W-1:0]);

    always_comb
    begin
        case (head_class) inside
            CH_SPACE, CH_NEWLINE, CH_LPAREN, CH_RPAREN, CH_QUOTE, CH_BQUOTE,
            CH_COMMA, CH_SEMI, CH_DQUOTE: ends_sym = 1'b1;
            default:                      ends_sym = 1'b0;
        endcase
    end

    always_comb
    begin
        d_mode  = MODE_IDLE;
        d_begin = 1'b1;
        d_emit  = 1'b0;
        d_digit = 1'b0;
        d_kind  = KIND_LPAREN;
        unique case (head_class) inside
            CH_SPACE, CH_NEWLINE, CH_END:
            begin
                d_begin = 1'b0;
            end
            CH_SEMI:
            begin
                d_begin = 1'b0;
                d_mode  = MODE_COMMENT;
            end
            CH_LPAREN:
            begin
                d_emit = 1'b1;
                d_kind = KIND_LPAREN;
            end
            CH_RPAREN:
            begin
                d_emit = 1'b1;
                d_kind = KIND_RPAREN;
            end
            CH_QUOTE:
            begin
                d_emit = 1'b1;
                d_kind = KIND_QUOTE;
            end
            CH_BQUOTE:
            begin
                d_emit = 1'b1;
                d_kind = KIND_BACKQUOTE;
            end
            CH_COMMA:  d_mode = MODE_COMMA;
            CH_DQUOTE: d_mode = MODE_STRING;
            CH_HASH:   d_mode = MODE_HASH;
            CH_DOT:    d_mode = MODE_DOT;
            CH_DIGIT:
            begin
                d_mode  = MODE_NUMBER;
                d_digit = 1'b1;
            end
            default:   d_mode = MODE_SYMBOL;
        endcase
    end

    always_comb
    begin
        mode_next       = mode_reg;
        dot_next        = dot_reg;
        fin_next        = fin_reg;
        offset_next     = offset_reg;
        line_next       = line_reg;
        line_start_next = line_start_reg;
        tok_off_next    = tok_off_reg;
        tok_line_next   = tok_line_reg;
        tok_col_next    = tok_col_reg;
        e0_v     = 1'b0;
        e0_kind  = KIND_SYMBOL;
        e0_bool  = 1'b0;
        e0_len   = span0;
        e1_v     = 1'b0;
        e1_kind  = KIND_END;
        e1_len   = '0;
        run_disp = 1'b0;

        if (consume && !fin_reg)
        begin
            if (head_class == CH_END)
            begin
                // flush pending token, end marker unless in a string
                mode_next = MODE_IDLE;
                fin_next  = 1'b1;
                e1_v      = 1'b1;
                unique case (mode_reg)
                    MODE_SYMBOL, MODE_HASH, MODE_DOT:
                    begin
                        e0_v    = 1'b1;
                        e0_kind = KIND_SYMBOL;
                    end
                    MODE_NUMBER:
                    begin
                        e0_v    = 1'b1;
                        e0_kind = KIND_NUMBER;
                    end
                    MODE_COMMA:
                    begin
                        e0_v    = 1'b1;
                        e0_kind = KIND_COMMA;
                        e0_len  = LEN_W'(1);
                    end
                    MODE_STRING, MODE_ESCAPE:
                    begin
                        e0_v    = 1'b1;
                        e0_kind = KIND_UNTERMINATED;
                        e1_v    = 1'b0;
                    end
                    default: ;
                endcase
                if (e1_v)
                begin
                    tok_off_next  = offset_reg;
                    tok_line_next = line_reg;
                    tok_col_next  = col_now;
                end
            end
            else
            begin
                unique case (mode_reg)
                    MODE_COMMENT:
                    begin
                        if (head_class == CH_NEWLINE)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_STRING:
                    begin
                        if (head_class == CH_DQUOTE)
                        begin
                            e0_v      = 1'b1;
                            e0_kind   = KIND_STRING;
                            e0_len    = span1;
                            mode_next = MODE_IDLE;
                        end
                        else if (head_class == CH_BSLASH)
                        begin
                            mode_next = MODE_ESCAPE;
                        end
                    end
                    MODE_ESCAPE:
                    begin
                        mode_next = MODE_STRING;
                    end
                    MODE_COMMA:
                    begin
                        e0_v = 1'b1;
                        if (head_class == CH_AT)
                        begin
                            e0_kind   = KIND_COMMA_AT;
                            e0_len    = LEN_W'(2);
                            mode_next = MODE_IDLE;
                        end
                        else
                        begin
                            e0_kind  = KIND_COMMA;
                            e0_len   = LEN_W'(1);
                            run_disp = 1'b1;
                        end
                    end
                    MODE_HASH, MODE_DOT, MODE_SYMBOL:
                    begin
                        if (mode_reg == MODE_HASH &&
                            (head_class == CH_TRUE || head_class == CH_FALSE))
                        begin
                            e0_v      = 1'b1;
                            e0_kind   = KIND_BOOLEAN;
                            e0_bool   = (head_class == CH_TRUE);
                            e0_len    = LEN_W'(2);
                            mode_next = MODE_IDLE;
                        end
                        else if (mode_reg == MODE_DOT && head_class == CH_DIGIT)
                        begin
                            dot_next  = 1'b1;
                            mode_next = MODE_NUMBER;
                        end
                        else if (ends_sym)
                        begin
                            e0_v     = 1'b1;
                            e0_kind  = KIND_SYMBOL;
                            run_disp = 1'b1;
                        end
                        else
                        begin
                            mode_next = MODE_SYMBOL;
                        end
                    end
                    MODE_NUMBER:
                    begin
                        if (head_class == CH_DIGIT)
                        begin
                            mode_next = MODE_NUMBER;
                        end
                        else if (head_class == CH_DOT && !dot_reg)
                        begin
                            dot_next = 1'b1;
                        end
                        else
                        begin
                            e0_v     = 1'b1;
                            e0_kind  = KIND_NUMBER;
                            run_disp = 1'b1;
                        end
                    end
                    default:
                    begin
                        run_disp = 1'b1;
                    end
                endcase

                if (run_disp)
                begin
                    mode_next = d_mode;
                    if (d_digit)
                    begin
                        dot_next = 1'b0;
                    end
                    if (d_begin)
                    begin
                        tok_off_next  = offset_reg;
                        tok_line_next = line_reg;
                        tok_col_next  = col_now;
                    end
                    e1_v    = d_emit;
                    e1_kind = d_kind;
                    e1_len  = LEN_W'(1);
                end

                // position counters, saturating
                if (offset_reg != '1)
                begin
                    offset_next = offset_reg + OB'(1);
                end
                if (head_class == CH_NEWLINE)
                begin
                    if (line_reg != '1)
                    begin
                        line_next = line_reg + LB'(1);
                    end
                    line_start_next = offset_next;
                end
            end
        end
    end

    // tdata layout: bool, offset, length, line, column
    assign td0 = TDATA_W'({tok_col_reg, tok_line_reg, e0_len, tok_off_reg, e0_bool});
    assign td1 = TDATA_W'({col_now, line_reg, e1_len, offset_reg, 1'b0});

    always_comb
    begin
        wr0_en   = e0_v || e1_v;
        wr1_en   = e0_v && e1_v;
        wr1_data = {1'b1, e1_kind, td1};
        if (e0_v)
        begin
            wr0_data = {!e1_v, e0_kind, td0};
        end
        else
        begin
            wr0_data = {1'b1, e1_kind, td1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            dot_reg        <= 1'b0;
            fin_reg        <= 1'b0;
            offset_reg     <= '0;
            line_reg       <= LB'(1);
            line_start_reg <= '0;
            tok_off_reg    <= '0;
            tok_line_reg   <= LB'(1);
            tok_col_reg    <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            dot_reg        <= dot_next;
            fin_reg        <= fin_next;
            offset_reg     <= offset_next;
            line_reg       <= line_next;
            line_start_reg <= line_start_next;
            tok_off_reg    <= tok_off_next;
            tok_line_reg   <= tok_line_next;
            tok_col_reg    <= tok_col_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/sexp_tokq.sv -----
// token queue: takes up to two tokens a cycle, hands out one per transaction
`default_nettype none

module sexp_tokq #(
    parameter int ENTRY_W = 101
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                wr0_en,
    input  wire  [ENTRY_W-1:0] wr0_data,
    input  wire                wr1_en,
    input  wire  [ENTRY_W-1:0] wr1_data,
    output logic               room,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [ENTRY_W-1:0] out_data
);
    import sexp_pkg::*;

    localparam int PTR_W = $clog2(TOKQ_DEPTH);

    logic [ENTRY_W-1:0] q_mem [TOKQ_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;
    logic               pop;

    // room for a full pair of tokens
    assign room      = (count_reg <= (PTR_W+1)'(TOKQ_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = q_mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(wr0_en) + PTR_W'(wr1_en);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + (PTR_W+1)'(wr0_en) + (PTR_W+1)'(wr1_en)
                    - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr0_en)
        begin
            q_mem[wr_ptr_reg] <= wr0_data;
        end
        if (wr1_en)
        begin
            q_mem[wr_ptr_reg + PTR_W'(1)] <= wr1_data;
        end
    end

endmodule

`default_nettype wire
